@@ rtl/core/bitmap_fit_allocator_defines.svh @@
// ============================================================================
// bitmap_fit_allocator_defines.svh
// Assertion macros used by the allocator RTL.
// ============================================================================
`ifndef BITMAP_FIT_ALLOCATOR_DEFINES_SVH
`define BITMAP_FIT_ALLOCATOR_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define BFA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BFA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/bfa_pkg.sv @@
// ============================================================================
// bfa_pkg
// Types and constants of the bitmap fit allocator.
// ============================================================================
package bfa_pkg;

    localparam int OP_W     = 2;
    localparam int START_W  = 10;
    localparam int LEN_W    = 11;
    localparam int POS_W    = 10;
    localparam int STAT_W   = 2;
    localparam int POL_W    = 2;
    localparam int SUM_W    = LEN_W + 1;

    // bitmap RAM word and scan digit
    localparam int WORD_W   = 32;
    localparam int WOFF_W   = 5;
    localparam int DIG_W    = 8;
    localparam int DIG_SH   = 3;
    localparam int BPW      = WORD_W / DIG_W;
    localparam int BSEL_W   = 2;

    localparam logic [OP_W-1:0] OP_FIND    = 2'd0;
    localparam logic [OP_W-1:0] OP_OCCUPY  = 2'd1;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;
    localparam logic [OP_W-1:0] OP_BAD     = 2'd3;

    localparam logic [POL_W-1:0] POL_FIRST = 2'd0;
    localparam logic [POL_W-1:0] POL_BEST  = 2'd1;
    localparam logic [POL_W-1:0] POL_WORST = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_MISS   = 2'd1;
    localparam logic [STAT_W-1:0] ST_BOUNDS = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]    opcode;
        logic [START_W-1:0] start_unit;
        logic [LEN_W-1:0]   length;
    } bfa_req_t;

    typedef struct packed {
        logic [POS_W-1:0]  position;
        logic [STAT_W-1:0] status;
    } bfa_rsp_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_FIND_RD,
        S_SCAN,
        S_CLOSE,
        S_CHK_RD,
        S_CHK,
        S_CHK_END,
        S_WR_RD,
        S_WR,
        S_DONE
    } bfa_state_t;

    typedef struct packed {
        logic load;     // capture request word
        logic clr;      // clearing pass write
        logic rd;       // read bitmap word at current index
        logic adv;      // step to next word and read it
        logic rewind;   // index to first word of range
        logic scan;     // run tracker over one digit
        logic close;    // run tracker sees a used unit
        logic chk;      // test range bits of current word
        logic wr;       // write back range bits of current word
        logic finish;   // load result register
    } bfa_cmd_t;

    typedef struct packed {
        logic at_end;    // index at last bitmap word
        logic at_last;   // index at last word of range
        logic last_byte;
        logic skip;      // out of bounds, bad opcode or zero length
        logic is_find;
        logic is_occ;
        logic miss;      // range holds used units
        logic rsp_busy;
    } bfa_sts_t;

endpackage

@@ rtl/core/bfa_ram.sv @@
// ============================================================================
// bfa_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module bfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                  clk,
    input  logic                  we,
    input  logic [ADDR_W-1:0]     waddr,
    input  logic [WIDTH-1:0]      wdata,
    input  logic                  re,
    input  logic [ADDR_W-1:0]     raddr,
    output logic [WIDTH-1:0]      rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/bfa_ctrl.sv @@
// ============================================================================
// bfa_ctrl
// Sequencer of the allocator: clearing pass, find scan, occupy check and
// range write-back.
// ============================================================================
module bfa_ctrl
    import bfa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  bfa_sts_t sts,
    output bfa_cmd_t cmd
);
    bfa_state_t state_reg;
    bfa_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr = 1'b1;
                if (sts.at_end)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (sts.skip)
                begin
                    state_next = S_DONE;
                end
                else if (sts.is_find)
                begin
                    state_next = S_FIND_RD;
                end
                else if (sts.is_occ)
                begin
                    cmd.rewind = 1'b1;
                    state_next = S_CHK_RD;
                end
                else
                begin
                    cmd.rewind = 1'b1;
                    state_next = S_WR_RD;
                end
            end
            S_FIND_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.last_byte)
                begin
                    if (sts.at_end)
                    begin
                        state_next = S_CLOSE;
                    end
                    else
                    begin
                        cmd.adv = 1'b1;
                    end
                end
            end
            S_CLOSE:
            begin
                // closes a free run that reaches the last unit
                cmd.close  = 1'b1;
                state_next = S_DONE;
            end
            S_CHK_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                cmd.chk = 1'b1;
                if (sts.at_last)
                begin
                    state_next = S_CHK_END;
                end
                else
                begin
                    cmd.adv = 1'b1;
                end
            end
            S_CHK_END:
            begin
                if (sts.miss)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.rewind = 1'b1;
                    state_next = S_WR_RD;
                end
            end
            S_WR_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_WR;
            end
            S_WR:
            begin
                cmd.wr = 1'b1;
                if (sts.at_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.adv = 1'b1;
                end
            end
            S_DONE:
            begin
                if (!sts.rsp_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/bfa_dpath.sv @@
// ============================================================================
// bfa_dpath
// Bitmap RAM, word index, range masks, free-run tracker, policy register
// and result register.
// ============================================================================
module bfa_dpath
    import bfa_pkg::*;
#(
    parameter int MEM_UNITS = 1024
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    input  logic [POL_W-1:0] cfg_data,
    input  bfa_req_t         req_data,
    input  bfa_cmd_t         cmd,
    output bfa_sts_t         sts,
    input  logic             rsp_ready,
    output logic             rsp_valid,
    output bfa_rsp_t         rsp_data
);
    localparam int WORDS = (MEM_UNITS + WORD_W - 1) / WORD_W;
    localparam int WA    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int CW0   = $clog2(MEM_UNITS + WORD_W);
    localparam int CW    = (CW0 > SUM_W) ? CW0 : SUM_W;

    logic [POL_W-1:0]  policy_reg;
    bfa_req_t          req_reg;
    logic [WA-1:0]     wcnt_reg;
    logic [BSEL_W-1:0] bcnt_reg;
    logic              miss_reg;
    logic [CW-1:0]     run_len_reg;
    logic [CW-1:0]     run_start_reg;
    logic              have_reg;
    logic [CW-1:0]     pick_pos_reg;
    logic [CW-1:0]     pick_len_reg;
    logic              rsp_valid_reg;
    bfa_rsp_t          rsp_reg;

    logic [CW-1:0]     run_len_next;
    logic [CW-1:0]     run_start_next;
    logic              have_next;
    logic [CW-1:0]     pick_pos_next;
    logic [CW-1:0]     pick_len_next;
    bfa_rsp_t          rsp_next;

    logic [CW-1:0]     start_ext;
    logic [CW-1:0]     end_ext;
    logic [CW-1:0]     end_ext_m1;
    logic [CW-1:0]     need;
    logic [WA-1:0]     first_word;
    logic [WA-1:0]     last_word;
    logic [CW-1:0]     word_base;
    logic [CW-1:0]     byte_base;
    logic [WORD_W-1:0] wmask;
    logic [DIG_W-1:0]  cur_byte;
    logic [DIG_W-1:0]  free_byte;
    logic              is_find;
    logic              is_occ;
    logic              bad;
    logic              empty;
    logic              first_mode;
    logic              best_mode;

    logic              ram_we;
    logic [WORD_W-1:0] ram_wdata;
    logic              ram_re;
    logic [WA-1:0]     ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    bfa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (WORDS)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wcnt_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // request decode
    assign start_ext  = CW'(req_reg.start_unit);
    assign end_ext    = CW'(req_reg.start_unit) + CW'(req_reg.length);
    assign need       = CW'(req_reg.length);
    assign first_word = start_ext[WA+WOFF_W-1:WOFF_W];
    assign last_word  = end_ext_m1[WA+WOFF_W-1:WOFF_W];
    assign is_find    = (req_reg.opcode == OP_FIND);
    assign is_occ     = (req_reg.opcode == OP_OCCUPY);
    assign empty      = (req_reg.length == '0);
    assign bad        = (req_reg.opcode == OP_BAD)
                      || (!is_find && (end_ext > CW'(MEM_UNITS)));
    assign first_mode = (policy_reg != POL_BEST) && (policy_reg != POL_WORST);
    assign best_mode  = (policy_reg == POL_BEST);

    assign end_ext_m1 = end_ext - CW'(1);

    assign word_base = CW'({wcnt_reg, {WOFF_W{1'b0}}});
    assign byte_base = word_base + CW'({bcnt_reg, {DIG_SH{1'b0}}});
    assign cur_byte  = ram_rdata[bcnt_reg*DIG_W +: DIG_W];

    // range bits within the current word
    always_comb
    begin
        logic [CW-1:0] unit;
        unit = '0;
        for (int i = 0; i < WORD_W; i++)
        begin
            unit     = word_base + CW'(i);
            wmask[i] = (unit >= start_ext) && (unit < end_ext);
        end
    end

    // free units of the current digit; padding past the end counts as used
    always_comb
    begin
        logic [CW-1:0] unit;
        unit = '0;
        for (int j = 0; j < DIG_W; j++)
        begin
            unit         = byte_base + CW'(j);
            free_byte[j] = cmd.scan && !cur_byte[j] && (unit < CW'(MEM_UNITS));
        end
    end

    // free-run tracker, one unit per step
    always_comb
    begin
        logic [CW-1:0] rl;
        logic [CW-1:0] rs;
        logic          hv;
        logic [CW-1:0] pp;
        logic [CW-1:0] pl;
        logic          take;
        rl   = run_len_reg;
        rs   = run_start_reg;
        hv   = have_reg;
        pp   = pick_pos_reg;
        pl   = pick_len_reg;
        take = 1'b0;
        for (int j = 0; j < DIG_W; j++)
        begin
            if (free_byte[j])
            begin
                if (rl == '0)
                begin
                    rs = byte_base + CW'(j);
                end
                rl = rl + CW'(1);
                if (first_mode && !hv && (rl == need))
                begin
                    hv = 1'b1;
                    pp = rs;
                end
            end
            else
            begin
                if (!first_mode && (rl >= need))
                begin
                    if (!hv)
                    begin
                        take = 1'b1;
                    end
                    else if (best_mode)
                    begin
                        take = (rl < pl);
                    end
                    else
                    begin
                        take = (rl > pl);
                    end
                    if (take)
                    begin
                        hv = 1'b1;
                        pp = rs;
                        pl = rl;
                    end
                end
                rl = '0;
            end
        end
        run_len_next   = rl;
        run_start_next = rs;
        have_next      = hv;
        pick_pos_next  = pp;
        pick_len_next  = pl;
    end

    // bitmap access
    assign ram_we    = cmd.clr || cmd.wr;
    assign ram_wdata = cmd.clr ? '0
                     : (is_occ ? (ram_rdata | wmask) : (ram_rdata & ~wmask));
    assign ram_re    = cmd.rd || cmd.adv;
    assign ram_raddr = cmd.adv ? (wcnt_reg + WA'(1)) : wcnt_reg;

    // result
    always_comb
    begin
        rsp_next.position = '0;
        rsp_next.status   = ST_OK;
        if (bad)
        begin
            rsp_next.status = ST_BOUNDS;
        end
        else if (is_find)
        begin
            if (empty || !have_reg)
            begin
                rsp_next.status = ST_MISS;
            end
            else
            begin
                rsp_next.position = pick_pos_reg[POS_W-1:0];
            end
        end
        else if (is_occ && miss_reg)
        begin
            rsp_next.status = ST_MISS;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg    <= POL_FIRST;
            wcnt_reg      <= '0;
            bcnt_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                policy_reg <= cfg_data;
            end
            if (cmd.load)
            begin
                wcnt_reg <= '0;
            end
            else if (cmd.rewind)
            begin
                wcnt_reg <= first_word;
            end
            else if (cmd.clr || cmd.adv)
            begin
                wcnt_reg <= wcnt_reg + WA'(1);
            end
            if (cmd.load)
            begin
                bcnt_reg <= '0;
            end
            else if (cmd.scan)
            begin
                bcnt_reg <= bcnt_reg + BSEL_W'(1);
            end
            if (cmd.finish)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg      <= req_data;
            miss_reg     <= 1'b0;
            run_len_reg  <= '0;
            run_start_reg <= '0;
            have_reg     <= 1'b0;
            pick_pos_reg <= '0;
            pick_len_reg <= '0;
        end
        else
        begin
            if (cmd.chk && ((ram_rdata & wmask) != '0))
            begin
                miss_reg <= 1'b1;
            end
            if (cmd.scan || cmd.close)
            begin
                run_len_reg   <= run_len_next;
                run_start_reg <= run_start_next;
                have_reg      <= have_next;
                pick_pos_reg  <= pick_pos_next;
                pick_len_reg  <= pick_len_next;
            end
        end
        if (cmd.finish)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign sts.at_end    = (wcnt_reg == WA'(WORDS - 1));
    assign sts.at_last   = (wcnt_reg == last_word);
    assign sts.last_byte = (bcnt_reg == BSEL_W'(BPW - 1));
    assign sts.skip      = bad || empty;
    assign sts.is_find   = is_find;
    assign sts.is_occ    = is_occ;
    assign sts.miss      = miss_reg;
    assign sts.rsp_busy  = rsp_valid_reg && !rsp_ready;

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

endmodule

@@ rtl/core/bitmap_fit_allocator.sv @@
// ============================================================================
// bitmap_fit_allocator
// Contiguous-run allocator over an occupancy bitmap with first, best and
// worst fit search.
// ============================================================================
// The bitmap lives in a RAM of 32-bit words, W = ceil(MEM_UNITS/32) words.
// After reset a clearing pass writes W words and no request is taken until
// it ends (configuration is taken at any time). A find scans the bitmap one
// 8-bit digit per cycle over all W words. Occupy runs over the N words its
// range touches as a check pass, then a read-modify-write pass (only the
// check pass when the range is not free); release runs the read-modify-
// write pass alone. Out-of-bounds, bad opcode and zero-length requests go
// straight to the result. One request is in work at a time; the result
// register lets a new request be accepted while the previous result
// waits.
`include "bitmap_fit_allocator_defines.svh"

module bitmap_fit_allocator
    import bfa_pkg::*;
#(
    parameter int MEM_UNITS = 1024
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [POL_W-1:0] cfg_data,
    input  logic             req_valid,
    output logic             req_ready,
    input  bfa_req_t         req_data,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output bfa_rsp_t         rsp_data
);
    bfa_cmd_t cmd;
    bfa_sts_t sts;

    assign cfg_ready = 1'b1;

    bfa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    bfa_dpath #(
        .MEM_UNITS (MEM_UNITS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .req_data  (req_data),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_ready (rsp_ready),
        .rsp_valid (rsp_valid),
        .rsp_data  (rsp_data)
    );

    `BFA_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready,
        "request taken while previous one still in work")
    `BFA_ASSERT_NOW(a_finish_slot_free, cmd.finish, !rsp_valid || rsp_ready,
        "result overwrote a word not yet taken")
    `BFA_ASSERT_NOW(a_no_accept_in_clear, cmd.clr, !req_ready && !cmd.wr,
        "request taken during clearing pass")

endmodule
